@@ sv/drt_pkg.sv @@
// ----------------------------------------------------------------------------
// drt_pkg: shared types and constants of the dirty rectangle tracker
// Widths, register indexes, item modes and the box and clip structs.
// ----------------------------------------------------------------------------
package drt_pkg;

  // Coordinate and size widths
  localparam int COORD_W = 12;
  localparam int IN_W    = 16;
  localparam int COUNT_W = 10;

  // Rectangles per frame before the frame collapses to full screen
  localparam int LIST_LIMIT = 512;

  // Reset screen size
  localparam logic [COORD_W-1:0] SCREEN_W_RESET = 12'd640;
  localparam logic [COORD_W-1:0] SCREEN_H_RESET = 12'd480;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } reg_index_t;

  // Input item modes
  typedef enum logic [0:0] {
    MODE_ADD  = 1'b0,
    MODE_FLIP = 1'b1
  } mode_t;

  // One bounding box, right and bottom exclusive
  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
  } box_t;

  // Clipper result for one rectangle
  typedef struct packed {
    logic screen_size;  // rectangle is exactly the screen size
    logic keep;         // something is left after clipping
    box_t box;          // clipped edges, meaningful when keep is set
  } clip_t;

  // Union result for one flip
  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
    logic               empty;
  } union_t;

endpackage

@@ sv/drt_clip.sv @@
// ----------------------------------------------------------------------------
// drt_clip: rectangle clipper
// Clips one signed rectangle to the screen and flags screen-sized input.
// ----------------------------------------------------------------------------
module drt_clip import drt_pkg::*; (
  input  logic [IN_W-1:0]    rect_x,
  input  logic [IN_W-1:0]    rect_y,
  input  logic [IN_W-1:0]    rect_w,
  input  logic [IN_W-1:0]    rect_h,
  input  logic [COORD_W-1:0] screen_width,
  input  logic [COORD_W-1:0] screen_height,
  output clip_t              clip
);

  logic signed [IN_W+1:0] x0, y0, x1, y1;
  logic signed [IN_W+1:0] x0c, y0c, x1c, y1c;
  logic signed [IN_W+1:0] sw, sh;

  // Extend edges and form far corners
  always_comb begin
    x0 = {{2{rect_x[IN_W-1]}}, rect_x};
    y0 = {{2{rect_y[IN_W-1]}}, rect_y};
    x1 = x0 + $signed({2'b00, rect_w});
    y1 = y0 + $signed({2'b00, rect_h});
    sw = $signed({{(IN_W+2-COORD_W){1'b0}}, screen_width});
    sh = $signed({{(IN_W+2-COORD_W){1'b0}}, screen_height});
  end

  // Clamp to the screen
  always_comb begin
    x0c = (x0 < 0) ? '0 : x0;
    y0c = (y0 < 0) ? '0 : y0;
    x1c = (x1 > sw) ? sw : x1;
    y1c = (y1 > sh) ? sh : y1;
  end

  // Pack result; edges fit in COORD_W whenever keep is set
  always_comb begin
    clip.screen_size = (rect_w == {{(IN_W-COORD_W){1'b0}}, screen_width}) &&
                       (rect_h == {{(IN_W-COORD_W){1'b0}}, screen_height});
    clip.keep        = (x1c > x0c) && (y1c > y0c);
    clip.box.left    = x0c[COORD_W-1:0];
    clip.box.top     = y0c[COORD_W-1:0];
    clip.box.right   = x1c[COORD_W-1:0];
    clip.box.bottom  = y1c[COORD_W-1:0];
  end

endmodule

@@ sv/drt_merge.sv @@
// ----------------------------------------------------------------------------
// drt_merge: frame union
// Joins the current and previous frame boxes into one update box.
// ----------------------------------------------------------------------------
module drt_merge import drt_pkg::*; (
  input  box_t   cur_box,
  input  logic   cur_valid,
  input  box_t   old_box,
  input  logic   old_valid,
  output union_t result
);

  box_t u;

  // Select or join the boxes that hold damage
  always_comb begin
    u = '0;
    if (cur_valid && old_valid) begin
      u.left   = (cur_box.left   < old_box.left)   ? cur_box.left   : old_box.left;
      u.top    = (cur_box.top    < old_box.top)    ? cur_box.top    : old_box.top;
      u.right  = (cur_box.right  > old_box.right)  ? cur_box.right  : old_box.right;
      u.bottom = (cur_box.bottom > old_box.bottom) ? cur_box.bottom : old_box.bottom;
    end else if (cur_valid) begin
      u = cur_box;
    end else if (old_valid) begin
      u = old_box;
    end
  end

  // Convert to corner and size
  always_comb begin
    result = '0;
    if (cur_valid || old_valid) begin
      result.left   = u.left;
      result.top    = u.top;
      result.width  = (u.right  >= u.left) ? u.right  - u.left : '0;
      result.height = (u.bottom >= u.top)  ? u.bottom - u.top  : '0;
      result.empty  = 1'b0;
    end else begin
      result.empty  = 1'b1;
    end
  end

endmodule

@@ sv/dirty_rect_bounding_tracker_core.sv @@
// ----------------------------------------------------------------------------
// dirty_rect_bounding_tracker_core: screen damage tracker
// Folds clipped rectangles into a per-frame bounding box and reports the
// union of the current and previous frames on each flip.
// ----------------------------------------------------------------------------
// The tracker takes one word per clock on the input channel. A word first
// lands in an input register; in the following cycle an add word is clipped
// and folded into the current box, and a flip word loads the output register.
// Add words never wait. A flip word waits in the input register only while
// the previous result is still held in the output register under stall, and
// the input channel stalls behind it. Screen size writes take effect on the
// next word processed and are accepted in every cycle.
module dirty_rect_bounding_tracker_core import drt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [COORD_W-1:0] cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic [IN_W-1:0]    rect_x,
  input  logic [IN_W-1:0]    rect_y,
  input  logic [IN_W-1:0]    rect_w,
  input  logic [IN_W-1:0]    rect_h,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COORD_W-1:0] out_left,
  output logic [COORD_W-1:0] out_top,
  output logic [COORD_W-1:0] out_width,
  output logic [COORD_W-1:0] out_height,
  output logic               out_empty
);

  // Configuration
  logic [COORD_W-1:0] screen_width;
  logic [COORD_W-1:0] screen_height;

  // Input register
  logic               s1_valid;
  logic               s1_mode;
  logic [IN_W-1:0]    s1_x, s1_y, s1_w, s1_h;
  logic               s1_fire;
  logic               s1_add;
  logic               s1_flip;
  logic               in_accept;

  // Frame state
  box_t               cur_box, old_box;
  logic               cur_valid, old_valid;
  logic [COUNT_W-1:0] rect_count;
  logic               full_screen;
  logic               go_full;

  clip_t              clip;
  union_t             result;

  // Accept configuration writes at any time
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_W_RESET;
      screen_height <= SCREEN_H_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold a flip while the output word is still stalled
  assign s1_add    = (mode_t'(s1_mode) == MODE_ADD);
  assign s1_flip   = (mode_t'(s1_mode) == MODE_FLIP);
  assign s1_fire   = s1_valid && !(s1_flip && out_valid && out_stall);
  assign in_stall  = s1_valid && !s1_fire;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_mode <= mode;
      s1_x    <= rect_x;
      s1_y    <= rect_y;
      s1_w    <= rect_w;
      s1_h    <= rect_h;
    end
  end

  drt_clip u_clip (
    .rect_x        (s1_x),
    .rect_y        (s1_y),
    .rect_w        (s1_w),
    .rect_h        (s1_h),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .clip          (clip)
  );

  drt_merge u_merge (
    .cur_box   (cur_box),
    .cur_valid (cur_valid),
    .old_box   (old_box),
    .old_valid (old_valid),
    .result    (result)
  );

  // Collapse to full screen on a screen-sized rectangle, a full list or a frame already full
  assign go_full = clip.screen_size || full_screen ||
                   (rect_count >= COUNT_W'(LIST_LIMIT));

  // Fold adds into the current frame; rotate frames on flip
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid   <= 1'b0;
      old_valid   <= 1'b0;
      rect_count  <= '0;
      full_screen <= 1'b0;
    end else if (s1_fire && s1_add) begin
      if (go_full) begin
        cur_valid   <= 1'b1;
        full_screen <= 1'b1;
        rect_count  <= COUNT_W'(1);
      end else if (clip.keep) begin
        cur_valid   <= 1'b1;
        rect_count  <= rect_count + COUNT_W'(1);
      end
    end else if (s1_fire && s1_flip) begin
      old_valid   <= cur_valid;
      cur_valid   <= 1'b0;
      rect_count  <= '0;
      full_screen <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_add) begin
      if (go_full) begin
        cur_box.left   <= '0;
        cur_box.top    <= '0;
        cur_box.right  <= screen_width;
        cur_box.bottom <= screen_height;
      end else if (clip.keep) begin
        if (!cur_valid) begin
          cur_box <= clip.box;
        end else begin
          if (clip.box.left < cur_box.left)     cur_box.left   <= clip.box.left;
          if (clip.box.top < cur_box.top)       cur_box.top    <= clip.box.top;
          if (clip.box.right > cur_box.right)   cur_box.right  <= clip.box.right;
          if (clip.box.bottom > cur_box.bottom) cur_box.bottom <= clip.box.bottom;
        end
      end
    end else if (s1_fire && s1_flip) begin
      old_box <= cur_box;
    end
  end

  // Output register: load on flip, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_flip) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_flip) begin
      out_left   <= result.left;
      out_top    <= result.top;
      out_width  <= result.width;
      out_height <= result.height;
      out_empty  <= result.empty;
    end
  end

  // Checks
  a_flip_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_flip) |=> (!cur_valid && rect_count == '0 && !full_screen))
    else $error("current frame not cleared after flip");

  a_full_is_valid: assert property (@(posedge clk) disable iff (rst)
    full_screen |-> cur_valid)
    else $error("full screen mark without a valid box");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (rect_count <= COUNT_W'(LIST_LIMIT)) && (cur_valid || rect_count == '0))
    else $error("rectangle count out of step with frame state");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_empty) |->
      (out_left == '0 && out_top == '0 && out_width == '0 && out_height == '0))
    else $error("empty result carries a nonzero box");

endmodule

@@ tb/sv/dirty_rect_bounding_tracker_core_tb.sv @@
// ----------------------------------------------------------------------------
// dirty_rect_bounding_tracker_core_tb: self-checking bench of the damage tracker
// Drives add and flip words with random gaps and output back-pressure. A local
// damage model predicts every union box, and a monitor checks each result
// field by field. The run walks through several screen sizes, zero and the
// extremes among them, and through one frame that overflows the list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dirty_rect_bounding_tracker_core_tb;
  import drt_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_AT_WORD = 250;
  localparam int HOLD_CYCLES  = 300;
  localparam int RAND_WORDS   = 135;
  localparam int LIST_WORDS   = 520;
  localparam int PRINT_CAP    = 25;

  // One input word as driven on the ports
  typedef struct packed {
    mode_t           mode;
    logic [IN_W-1:0] x;
    logic [IN_W-1:0] y;
    logic [IN_W-1:0] w;
    logic [IN_W-1:0] h;
  } rect_word_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  reg_index_t         cfg_index = REG_SCREEN_WIDTH;
  logic [COORD_W-1:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  rect_word_t         offer = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [COORD_W-1:0] out_left;
  logic [COORD_W-1:0] out_top;
  logic [COORD_W-1:0] out_width;
  logic [COORD_W-1:0] out_height;
  logic               out_empty;

  // Damage model state
  logic [COORD_W-1:0] scr_w;
  logic [COORD_W-1:0] scr_h;
  box_t               cur_box;
  box_t               old_box;
  logic               cur_live;
  logic               old_live;
  int unsigned        rect_cnt;
  logic               full_mark;

  // Pending words and predicted unions
  rect_word_t         word_q[$];
  union_t             union_q[$];

  // Run bookkeeping
  int unsigned cycles;
  int unsigned words_taken;
  int unsigned n_results;
  int unsigned fails;
  int unsigned n_kept;
  int unsigned n_dropped;
  int unsigned n_full;
  int unsigned n_flips;
  int unsigned n_empty;
  int unsigned n_settings;
  logic        word_taken = 1'b0;
  logic        tx_quiet = 1'b0;
  logic        rx_quiet = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned tx_gap;
  int unsigned rx_gap;
  int unsigned rx_hold;

  dirty_rect_bounding_tracker_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (offer.mode),
    .rect_x    (offer.x),
    .rect_y    (offer.y),
    .rect_w    (offer.w),
    .rect_h    (offer.h),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_left  (out_left),
    .out_top   (out_top),
    .out_width (out_width),
    .out_height(out_height),
    .out_empty (out_empty)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Damage model
  // ---------------------------------------------------------------------------

  // Empty the current frame; edges reload to the inverted screen box
  task automatic clear_frame();
    cur_box   = '{left: scr_w, top: scr_h, right: '0, bottom: '0};
    cur_live  = 1'b0;
    rect_cnt  = 0;
    full_mark = 1'b0;
  endtask

  task automatic go_full_screen();
    cur_box   = '{left: '0, top: '0, right: scr_w, bottom: scr_h};
    cur_live  = 1'b1;
    full_mark = 1'b1;
    rect_cnt  = 1;
    n_full++;
  endtask

  // Fold one accepted word into the model; a flip queues its union
  task automatic track_word(input rect_word_t wd);
    int     x0;
    int     y0;
    int     x1;
    int     y1;
    box_t   ub;
    union_t res;
    if (wd.mode == MODE_ADD) begin
      x0 = int'($signed(wd.x));
      y0 = int'($signed(wd.y));
      x1 = x0 + int'(wd.w);
      y1 = y0 + int'(wd.h);
      if (wd.w == scr_w && wd.h == scr_h) begin
        go_full_screen();
      end else if (rect_cnt >= LIST_LIMIT || full_mark) begin
        go_full_screen();
      end else begin
        // clip to the screen, then drop anything with no area left
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        if (x1 > int'(scr_w)) x1 = int'(scr_w);
        if (y1 > int'(scr_h)) y1 = int'(scr_h);
        if (x1 <= x0 || y1 <= y0) begin
          n_dropped++;
        end else begin
          if (!cur_live) begin
            cur_box = '{left: COORD_W'(x0), top: COORD_W'(y0),
                        right: COORD_W'(x1), bottom: COORD_W'(y1)};
          end else begin
            if (COORD_W'(x0) < cur_box.left)   cur_box.left   = COORD_W'(x0);
            if (COORD_W'(y0) < cur_box.top)    cur_box.top    = COORD_W'(y0);
            if (COORD_W'(x1) > cur_box.right)  cur_box.right  = COORD_W'(x1);
            if (COORD_W'(y1) > cur_box.bottom) cur_box.bottom = COORD_W'(y1);
          end
          cur_live = 1'b1;
          rect_cnt = (rect_cnt + 1) % 1024;
          n_kept++;
        end
      end
    end else begin
      res = '0;
      if (cur_live && old_live) begin
        ub.left   = (cur_box.left < old_box.left)     ? cur_box.left   : old_box.left;
        ub.top    = (cur_box.top < old_box.top)       ? cur_box.top    : old_box.top;
        ub.right  = (cur_box.right > old_box.right)   ? cur_box.right  : old_box.right;
        ub.bottom = (cur_box.bottom > old_box.bottom) ? cur_box.bottom : old_box.bottom;
      end else if (cur_live) begin
        ub = cur_box;
      end else begin
        ub = old_box;
      end
      if (cur_live || old_live) begin
        res.left   = ub.left;
        res.top    = ub.top;
        res.width  = (ub.right >= ub.left) ? ub.right - ub.left : '0;
        res.height = (ub.bottom >= ub.top) ? ub.bottom - ub.top : '0;
      end else begin
        res.empty = 1'b1;
        n_empty++;
      end
      union_q.push_back(res);
      n_flips++;
      // age the frame
      old_box  = cur_box;
      old_live = cur_live;
      clear_frame();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly short gaps, a few long ones
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 90) return $urandom_range(3, 8);
    if (r < 98) return $urandom_range(9, 30);
    return $urandom_range(40, 80);
  endfunction

  task automatic push_add(input int x, input int y, input int w, input int h);
    rect_word_t wd;
    wd.mode = MODE_ADD;
    wd.x    = IN_W'(x);
    wd.y    = IN_W'(y);
    wd.w    = IN_W'(w);
    wd.h    = IN_W'(h);
    word_q.push_back(wd);
  endtask

  // Flip payload is don't-care to the block; keep it random
  function automatic rect_word_t flip_word();
    rect_word_t wd;
    wd.mode = MODE_FLIP;
    wd.x    = IN_W'($urandom);
    wd.y    = IN_W'($urandom);
    wd.w    = IN_W'($urandom);
    wd.h    = IN_W'($urandom);
    return wd;
  endfunction

  // Random add, shaped around the current screen size
  function automatic rect_word_t rand_add();
    rect_word_t  wd;
    int unsigned pick;
    int unsigned sw;
    int unsigned sh;
    int unsigned rx;
    int unsigned ry;
    int unsigned rw;
    int unsigned rh;
    sw      = 32'(scr_w);
    sh      = 32'(scr_h);
    wd      = '0;
    wd.mode = MODE_ADD;
    pick    = $urandom_range(0, 99);
    if (pick < 50) begin
      // on screen, mostly small
      rx = (sw > 1) ? $urandom_range(0, sw - 1) : 0;
      ry = (sh > 1) ? $urandom_range(0, sh - 1) : 0;
      rw = ($urandom_range(0, 9) == 0) ? $urandom_range(1, sw + 8) : $urandom_range(1, 48);
      rh = ($urandom_range(0, 9) == 0) ? $urandom_range(1, sh + 8) : $urandom_range(1, 48);
    end else if (pick < 65) begin
      // straddle an edge
      rx = $urandom_range(0, 1) ? -$urandom_range(1, 64) : sw - $urandom_range(0, 32);
      ry = $urandom_range(0, 1) ? -$urandom_range(1, 64) : sh - $urandom_range(0, 32);
      rw = $urandom_range(1, 128);
      rh = $urandom_range(1, 128);
    end else if (pick < 73) begin
      // wholly off screen, left or right
      rx = $urandom_range(0, 1) ? -$urandom_range(65, 400) : sw + $urandom_range(0, 2000);
      ry = $urandom_range(0, sh);
      rw = $urandom_range(1, 64);
      rh = $urandom_range(1, 64);
    end else if (pick < 80) begin
      // zero area
      rx = $urandom_range(0, sw);
      ry = $urandom_range(0, sh);
      rw = $urandom_range(0, 1) ? 0 : $urandom_range(0, 100);
      rh = (rw == 0) ? $urandom_range(0, 100) : 0;
    end else if (pick < 85) begin
      // exactly the screen size anywhere
      rx = $urandom;
      ry = $urandom;
      rw = sw;
      rh = sh;
    end else begin
      rx = $urandom;
      ry = $urandom;
      rw = $urandom;
      rh = $urandom;
    end
    wd.x = IN_W'(rx);
    wd.y = IN_W'(ry);
    wd.w = IN_W'(rw);
    wd.h = IN_W'(rh);
    return wd;
  endfunction

  function automatic rect_word_t rand_word();
    if ($urandom_range(0, 7) == 0) return flip_word();
    return rand_add();
  endfunction

  // Write one screen register over the config channel
  task automatic write_reg(input reg_index_t idx, input logic [COORD_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_SCREEN_WIDTH) scr_w = val;
    else scr_h = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_screen(input int unsigned w, input int unsigned h);
    write_reg(REG_SCREEN_WIDTH, COORD_W'(w));
    write_reg(REG_SCREEN_HEIGHT, COORD_W'(h));
    n_settings++;
  endtask

  // Hold off until every word is taken and every union has come back
  task automatic wait_idle();
    do @(posedge clk); while (word_q.size() != 0 || in_valid || union_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    if (fails < PRINT_CAP) $display("MISMATCH at cycle %0d: %s", cycles, msg);
    fails++;
  endtask

  // ---------------------------------------------------------------------------
  // Input side: offer words, take on valid and not stall
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    word_taken = !rst && in_valid && !in_stall;
    if (word_taken) begin
      track_word(offer);
      words_taken++;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !word_taken) begin
      // hold the stalled word
    end else if (tx_gap > 0) begin
      tx_gap--;
      in_valid <= 1'b0;
    end else if (word_q.size() != 0) begin
      offer = word_q.pop_front();
      in_valid <= 1'b1;
      tx_gap = (!tx_quiet && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: random stall, one long hold once the stream is busy
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_stall <= 1'b1;
    end else if (!hold_done && words_taken >= HOLD_AT_WORD) begin
      rx_hold = HOLD_CYCLES - 1;
      hold_done = 1'b1;
      out_stall <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_stall <= 1'b1;
    end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
      rx_gap = gap_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check each union against the oldest prediction
  always @(posedge clk) begin
    union_t want;
    if (!rst && out_valid && !out_stall) begin
      if (union_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", n_results));
      end else begin
        want = union_q.pop_front();
        if (out_left !== want.left)
          report_mismatch($sformatf("result %0d left %0d, want %0d",
                                    n_results, out_left, want.left));
        if (out_top !== want.top)
          report_mismatch($sformatf("result %0d top %0d, want %0d",
                                    n_results, out_top, want.top));
        if (out_width !== want.width)
          report_mismatch($sformatf("result %0d width %0d, want %0d",
                                    n_results, out_width, want.width));
        if (out_height !== want.height)
          report_mismatch($sformatf("result %0d height %0d, want %0d",
                                    n_results, out_height, want.height));
        if (out_empty !== want.empty)
          report_mismatch($sformatf("result %0d empty %0b, want %0b",
                                    n_results, out_empty, want.empty));
      end
      n_results++;
    end
  end

  // Cycle count, idle-free stretches, and the watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles % 200 == 0) begin
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words taken, %0d unions pending",
               cycles, words_taken, union_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Phases
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned sw_pick;
    int unsigned sh_pick;

    scr_w = SCREEN_W_RESET;
    scr_h = SCREEN_H_RESET;
    clear_frame();
    old_box  = cur_box;
    old_live = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words at the reset screen size
    word_q.push_back(flip_word());               // nothing damaged yet
    push_add(0, 0, 1, 1);                        // top-left pixel
    push_add(639, 479, 1, 1);                    // bottom-right pixel
    push_add(-32768, -32768, 65535, 65535);      // huge, clips to whole screen
    word_q.push_back(flip_word());
    push_add(32767, 32767, 65535, 65535);        // far off screen
    push_add(10, 10, 0, 5);                      // zero width
    push_add(-5, 20, 5, 10);                     // ends on the left edge
    push_add(100, 50, 640, 480);                 // screen-sized at an offset
    push_add(1, 1, 2, 2);                        // while already full screen
    word_q.push_back(flip_word());
    word_q.push_back(flip_word());               // previous frame only
    word_q.push_back(flip_word());               // both frames empty
    push_add(-10, -10, 30, 40);                  // clipped top-left
    push_add(600, 400, 100, 100);                // clipped bottom-right
    push_add(-1, 479, 2, 65535);
    word_q.push_back(flip_word());
    push_add(0, 0, 640, 480);                    // screen-sized at origin
    word_q.push_back(flip_word());
    wait_idle();

    // Zero screen: ordinary rectangles vanish, a zero-sized one fills it
    set_screen(0, 0);
    push_add(3, 3, 10, 10);
    push_add(-4, -4, 8, 8);
    word_q.push_back(flip_word());
    push_add(0, 0, 0, 0);
    word_q.push_back(flip_word());
    word_q.push_back(flip_word());
    wait_idle();

    // Random phases; frames may stay open across a screen change
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin sw_pick = 4095; sh_pick = 4095; end
        1: begin sw_pick = 1;    sh_pick = 1;    end
        3: begin sw_pick = 4095; sh_pick = 1;    end
        4: begin sw_pick = 800;  sh_pick = 600;  end
        5: begin sw_pick = 1;    sh_pick = 4095; end
        default: begin
          sw_pick = $urandom_range(1, 4095);
          sh_pick = $urandom_range(1, 4095);
        end
      endcase
      set_screen(sw_pick, sh_pick);
      if (p == 4) begin
        // overflow the rectangle list within one frame
        word_q.push_back(flip_word());
        repeat (LIST_WORDS)
          push_add($urandom_range(0, 799), $urandom_range(0, 599),
                   $urandom_range(1, 40), $urandom_range(1, 40));
        word_q.push_back(flip_word());
      end
      repeat (RAND_WORDS) word_q.push_back(rand_word());
      wait_idle();
    end

    $display("Ran %0d words over %0d screen settings: %0d flips (%0d empty), %0d unions checked",
             words_taken, n_settings, n_flips, n_empty, n_results);
    $display("Rectangles folded %0d, dropped %0d, full-screen collapses %0d, %0d mismatches",
             n_kept, n_dropped, n_full, fails);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/drt_pkg.sv
sv/drt_clip.sv
sv/drt_merge.sv
sv/dirty_rect_bounding_tracker_core.sv
tb/sv/dirty_rect_bounding_tracker_core_tb.sv
